// File: hdl/sfsu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfsu_pkg
// Shared types, constants and helpers of the starfield star update block.
// ----------------------------------------------------------------------------
package sfsu_pkg;

  localparam int MAX_STARS_DEF = 256;
  localparam int COORD_W       = 12;
  localparam int Q_W           = 21;  // numerator / quotient magnitude width
  localparam int DIV_STEP      = 3;   // quotient bits per divider cycle
  localparam int DEN_W         = 13;  // divisor z+1000 lies in 1..5095

  localparam logic [1:0] PEN_ERASE  = 2'd0;
  localparam logic [1:0] PEN_FAR    = 2'd1;
  localparam logic [1:0] PEN_MIDDLE = 2'd2;
  localparam logic [1:0] PEN_NEAR   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_WB
  } state_e;

  typedef enum logic [1:0] {
    REG_BASE_SPEED    = 2'd0,
    REG_SCREEN_WIDTH  = 2'd1,
    REG_SCREEN_HEIGHT = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    KIND_QUAD,
    KIND_PAIR,
    KIND_SINGLE
  } kind_e;

  typedef struct packed {
    logic [11:0] pos_x;
    logic [10:0] pos_y;
    logic [12:0] depth_z;
    logic [9:0]  speed;
    logic [11:0] drawn_x;
    logic [11:0] drawn_y;
  } star_t;

  typedef struct packed {
    logic                 start;
    logic signed [Q_W-1:0] num_x;
    logic signed [Q_W-1:0] num_y;
    logic [DEN_W-1:0]      den;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic signed [Q_W:0] qx;
    logic signed [Q_W:0] qy;
  } div_rsp_t;

  typedef struct packed {
    logic [COORD_W-1:0] erase_x;
    logic [COORD_W-1:0] erase_y;
    kind_e              erase_kind;
    logic               draw_en;
    logic [COORD_W-1:0] draw_x;
    logic [COORD_W-1:0] draw_y;
    kind_e              draw_kind;
    logic [1:0]         pen;
  } desc_t;

  function automatic star_t respawn(input logic [11:0] rx, input logic [10:0] ry,
                                    input logic [10:0] rz, input logic [3:0] rs,
                                    input logic [9:0] base);
    star_t s;
    s.pos_x   = 12'd1500 - rx;
    s.pos_y   = 11'd1000 - ry;
    s.depth_z = 13'd1000 + {2'b00, rz};
    s.speed   = base + {6'd0, rs};
    s.drawn_x = '0;
    s.drawn_y = '0;
    return s;
  endfunction

  // Pixel pattern of a depth band (z/200 truncated, decided by z ranges).
  function automatic kind_e band_kind(input logic signed [13:0] z);
    kind_e k;
    if (z >= -14'sd199 && z <= 14'sd199) k = KIND_QUAD;
    else if (z >= 14'sd200 && z <= 14'sd999) k = KIND_PAIR;
    else k = KIND_SINGLE;
    return k;
  endfunction

  function automatic logic [1:0] band_pen(input logic signed [13:0] z);
    logic [1:0] p;
    if (z >= -14'sd199 && z <= 14'sd1599) p = PEN_NEAR;
    else if (z >= 14'sd1600 && z <= 14'sd1999) p = PEN_MIDDLE;
    else p = PEN_FAR;
    return p;
  endfunction

  function automatic logic [2:0] kind_count(input kind_e k);
    logic [2:0] n;
    unique case (k)
      KIND_QUAD: n = 3'd4;
      KIND_PAIR: n = 3'd2;
      default:   n = 3'd1;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// File: hdl/sfsu_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfsu_div
// Two-lane signed divider by a shared positive divisor, truncating toward
// zero, several restoring steps per cycle.
// ----------------------------------------------------------------------------
module sfsu_div #(
  parameter int QW   = sfsu_pkg::Q_W,
  parameter int STEP = sfsu_pkg::DIV_STEP,
  parameter int DW   = sfsu_pkg::DEN_W
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  sfsu_pkg::div_req_t req_i,
  output sfsu_pkg::div_rsp_t rsp_o
);

  localparam int ITER  = (QW + STEP - 1) / STEP;
  localparam int CNT_W = $clog2(ITER + 1);

  logic [QW-1:0]    sh_q  [2];
  logic [QW-1:0]    sh_d  [2];
  logic [DW-1:0]    rem_q [2];
  logic [DW-1:0]    rem_d [2];
  logic             neg_q [2];
  logic [DW-1:0]    den_q;
  logic [CNT_W-1:0] cnt_q;

  always_comb begin
    logic [DW-1:0] r;
    logic [QW-1:0] s;
    logic [DW:0]   t;
    for (int l = 0; l < 2; l++) begin
      r = rem_q[l];
      s = sh_q[l];
      for (int k = 0; k < STEP; k++) begin
        t = {r, s[QW-1]};
        s = {s[QW-2:0], 1'b0};
        if (t >= {1'b0, den_q}) begin
          t    = t - {1'b0, den_q};
          s[0] = 1'b1;
        end
        r = t[DW-1:0];
      end
      rem_d[l] = r;
      sh_d[l]  = s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (req_i.start) begin
      cnt_q <= CNT_W'(ITER);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q    <= req_i.den;
      neg_q[0] <= req_i.num_x[QW-1];
      neg_q[1] <= req_i.num_y[QW-1];
      sh_q[0]  <= req_i.num_x[QW-1] ? QW'(-req_i.num_x) : QW'(req_i.num_x);
      sh_q[1]  <= req_i.num_y[QW-1] ? QW'(-req_i.num_y) : QW'(req_i.num_y);
      rem_q[0] <= '0;
      rem_q[1] <= '0;
    end else if (cnt_q != '0) begin
      sh_q  <= sh_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.busy = (cnt_q != '0);
  assign rsp_o.qx   = neg_q[0] ? -$signed({1'b0, sh_q[0]}) : $signed({1'b0, sh_q[0]});
  assign rsp_o.qy   = neg_q[1] ? -$signed({1'b0, sh_q[1]}) : $signed({1'b0, sh_q[1]});

endmodule
`default_nettype wire

// File: hdl/sfsu_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfsu_emit
// Holds one pixel descriptor and walks it: erase pixels, then draw pixels if
// enabled, one beat per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module sfsu_emit (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  sfsu_pkg::desc_t     desc_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic [11:0]         pixel_x_o,
  output logic [11:0]         pixel_y_o,
  output logic [1:0]          pen_o,
  output logic                last_pixel_o
);

  sfsu_pkg::desc_t desc_q;
  logic            full_q;
  logic            draw_q;
  logic [2:0]      cnt_q;
  logic            beat;
  logic            last;
  logic            dx;
  logic            dy;

  assign beat    = full_q && out_ready_i;
  assign last    = (cnt_q == 3'd1) && (draw_q || !desc_q.draw_en);
  assign ready_o = !full_q || (beat && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      draw_q <= 1'b0;
      cnt_q  <= '0;
    end else if (push_i) begin
      full_q <= 1'b1;
      draw_q <= 1'b0;
      cnt_q  <= sfsu_pkg::kind_count(desc_i.erase_kind);
    end else if (beat) begin
      if (cnt_q == 3'd1) begin
        if (last) begin
          full_q <= 1'b0;
        end else begin
          draw_q <= 1'b1;
          cnt_q  <= sfsu_pkg::kind_count(desc_q.draw_kind);
        end
      end else begin
        cnt_q <= cnt_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      desc_q <= desc_i;
    end
  end

  // Count down the pattern: 4 (x,y+1), 3 (x+1,y+1), 2 (x+1,y), 1 (x,y).
  assign dx = (cnt_q == 3'd2) || (cnt_q == 3'd3);
  assign dy = (cnt_q == 3'd3) || (cnt_q == 3'd4);

  assign out_valid_o  = full_q;
  assign pixel_x_o    = (draw_q ? desc_q.draw_x : desc_q.erase_x) + {11'd0, dx};
  assign pixel_y_o    = (draw_q ? desc_q.draw_y : desc_q.erase_y) + {11'd0, dy};
  assign pen_o        = draw_q ? desc_q.pen : sfsu_pkg::PEN_ERASE;
  assign last_pixel_o = last;

endmodule
`default_nettype wire

// File: hdl/starfield_star_update.sv
`default_nettype none
// An advance beat reads the table, runs the divider and writes back, handing
// a pixel descriptor to the emitter; an init beat writes the table in the
// cycle after acceptance and gives no pixels. A new beat is taken only when
// idle or at write back; pixels drain in parallel, up to 8 per beat.
// Reset clears control state and loads the register defaults; the star table
// is not cleared and holds garbage until each entry is initialized.
// ----------------------------------------------------------------------------
// starfield_star_update
// Star table update: init a star, or erase old pixel, move, project, respawn, draw new pixel.
// ----------------------------------------------------------------------------
module starfield_star_update #(
  parameter int MAX_STARS = sfsu_pkg::MAX_STARS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire         func_i,
  input  wire  [7:0]  star_index_i,
  input  wire  [11:0] rand_x_a_i,
  input  wire  [10:0] rand_y_a_i,
  input  wire  [10:0] rand_z_a_i,
  input  wire  [3:0]  rand_speed_a_i,
  input  wire  [11:0] rand_x_b_i,
  input  wire  [10:0] rand_y_b_i,
  input  wire  [10:0] rand_z_b_i,
  input  wire  [3:0]  rand_speed_b_i,
  // output channel
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [11:0] pixel_x_o,
  output logic [11:0] pixel_y_o,
  output logic [1:0]  pen_o,
  output logic        last_pixel_o
);

  localparam int IW = (MAX_STARS > 1) ? $clog2(MAX_STARS) : 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [9:0]  base_speed_q;
  logic [12:0] width_q;
  logic [12:0] height_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_speed_q <= 10'd100;
      width_q      <= 13'd640;
      height_q     <= 13'd480;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        sfsu_pkg::REG_BASE_SPEED:    base_speed_q <= pwdata[9:0];
        sfsu_pkg::REG_SCREEN_WIDTH:  width_q      <= pwdata[12:0];
        sfsu_pkg::REG_SCREEN_HEIGHT: height_q     <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      sfsu_pkg::REG_BASE_SPEED:    prdata = {22'd0, base_speed_q};
      sfsu_pkg::REG_SCREEN_WIDTH:  prdata = {19'd0, width_q};
      sfsu_pkg::REG_SCREEN_HEIGHT: prdata = {19'd0, height_q};
      default:                     prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  sfsu_pkg::state_e state_q, state_d;
  logic             func_q;
  logic             accept;
  logic             take;
  logic             desc_ready;
  logic             mem_we;
  logic             desc_push;
  logic             div_start;
  sfsu_pkg::div_rsp_t div_rsp;

  assign accept = in_valid_i && in_ready_o;
  // Drop beats that point past the table.
  assign take   = accept && (32'(star_index_i) < MAX_STARS);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sfsu_pkg::ST_IDLE: if (take) state_d = sfsu_pkg::ST_LOAD;
      sfsu_pkg::ST_LOAD: state_d = func_q ? sfsu_pkg::ST_DIV : sfsu_pkg::ST_IDLE;
      sfsu_pkg::ST_DIV:  if (!div_rsp.busy) state_d = sfsu_pkg::ST_WB;
      sfsu_pkg::ST_WB: begin
        if (desc_ready) state_d = take ? sfsu_pkg::ST_LOAD : sfsu_pkg::ST_IDLE;
      end
      default: state_d = sfsu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    desc_push  = 1'b0;
    div_start  = 1'b0;
    unique case (state_q)
      sfsu_pkg::ST_IDLE: in_ready_o = 1'b1;
      sfsu_pkg::ST_LOAD: begin
        mem_we    = !func_q;
        div_start = func_q;
      end
      sfsu_pkg::ST_DIV: ;
      sfsu_pkg::ST_WB: begin
        // Overlap: take the next beat while this one writes back.
        in_ready_o = desc_ready;
        mem_we     = desc_ready;
        desc_push  = desc_ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfsu_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Beat payload
  // --------------------------------------------------------------------------
  logic [IW-1:0] idx_q;
  logic [11:0]   rxa_q, rxb_q;
  logic [10:0]   rya_q, ryb_q, rza_q, rzb_q;
  logic [3:0]    rsa_q, rsb_q;
  logic [IW-1:0] in_addr;

  assign in_addr = IW'(star_index_i);

  always_ff @(posedge clk_i) begin
    if (take) begin
      func_q <= func_i;
      idx_q  <= in_addr;
      rxa_q  <= rand_x_a_i;
      rya_q  <= rand_y_a_i;
      rza_q  <= rand_z_a_i;
      rsa_q  <= rand_speed_a_i;
      rxb_q  <= rand_x_b_i;
      ryb_q  <= rand_y_b_i;
      rzb_q  <= rand_z_b_i;
      rsb_q  <= rand_speed_b_i;
    end
  end

  // --------------------------------------------------------------------------
  // Star table: one write port, one registered read port
  // --------------------------------------------------------------------------
  sfsu_pkg::star_t mem [MAX_STARS];
  sfsu_pkg::star_t rd_q;
  sfsu_pkg::star_t wr_data;
  sfsu_pkg::star_t fwd_data_q;
  logic            fwd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[idx_q] <= wr_data;
    end
    if (take) begin
      rd_q <= mem[in_addr];
    end
  end

  // A beat taken during write back of the same star reads stale data:
  // forward the write instead.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (take) begin
      fwd_q <= (state_q == sfsu_pkg::ST_WB) && (in_addr == idx_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      fwd_data_q <= wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // Load: erase band, move, first respawn, divider operands
  // --------------------------------------------------------------------------
  sfsu_pkg::star_t       cur;
  sfsu_pkg::star_t       spawn_a;
  sfsu_pkg::star_t       mid;
  sfsu_pkg::star_t       mid_q;
  logic signed [13:0]    z_old;
  logic signed [13:0]    z_new;
  logic signed [13:0]    z_mid;
  sfsu_pkg::div_req_t    div_req;
  sfsu_pkg::kind_e       ekind_q, dkind_q;
  logic [1:0]            dpen_q;
  logic [11:0]           ex_q, ey_q;

  assign cur     = fwd_q ? fwd_data_q : rd_q;
  assign spawn_a = sfsu_pkg::respawn(rxa_q, rya_q, rza_q, rsa_q, base_speed_q);
  assign z_old   = $signed({cur.depth_z[12], cur.depth_z});
  assign z_new   = z_old - $signed({4'd0, cur.speed});

  always_comb begin
    mid         = cur;
    mid.depth_z = z_new[12:0];
    // Past the viewer: respawn from the first random set.
    if (z_new <= -14'sd1000) begin
      mid.pos_x   = spawn_a.pos_x;
      mid.pos_y   = spawn_a.pos_y;
      mid.depth_z = spawn_a.depth_z;
      mid.speed   = spawn_a.speed;
    end
  end

  assign z_mid         = $signed({mid.depth_z[12], mid.depth_z});
  assign div_req.start = div_start;
  assign div_req.num_x = $signed({{9{mid.pos_x[11]}}, mid.pos_x}) * 21'sd200;
  assign div_req.num_y = $signed({{10{mid.pos_y[10]}}, mid.pos_y}) * 21'sd200;
  assign div_req.den   = 13'(z_mid + 14'sd1000);

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      mid_q   <= mid;
      ekind_q <= sfsu_pkg::band_kind(z_old);
      ex_q    <= cur.drawn_x;
      ey_q    <= cur.drawn_y;
      dkind_q <= sfsu_pkg::band_kind(z_mid);
      dpen_q  <= sfsu_pkg::band_pen(z_mid);
    end
  end

  sfsu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Write back: place on screen, second respawn, pixel descriptor
  // --------------------------------------------------------------------------
  logic signed [21:0] px, py, lim_x, lim_y;
  logic               off_screen;
  sfsu_pkg::star_t    spawn_b;
  sfsu_pkg::desc_t    desc;

  assign px    = $signed({10'd0, 12'(width_q >> 1)}) + div_rsp.qx;
  assign py    = $signed({10'd0, 12'(height_q >> 1)}) + div_rsp.qy;
  assign lim_x = $signed({9'd0, width_q}) - 22'sd2;
  assign lim_y = $signed({9'd0, height_q}) - 22'sd2;
  assign off_screen = (px < 22'sd0) || (px > lim_x) || (py < 22'sd0) || (py > lim_y);

  assign spawn_b = sfsu_pkg::respawn(rxb_q, ryb_q, rzb_q, rsb_q, base_speed_q);

  always_comb begin
    if (state_q == sfsu_pkg::ST_LOAD) begin
      wr_data = spawn_a;
    end else if (off_screen) begin
      wr_data = spawn_b;
    end else begin
      wr_data         = mid_q;
      wr_data.drawn_x = px[11:0];
      wr_data.drawn_y = py[11:0];
    end
  end

  assign desc.erase_x    = ex_q;
  assign desc.erase_y    = ey_q;
  assign desc.erase_kind = ekind_q;
  assign desc.draw_en    = !off_screen;
  assign desc.draw_x     = px[11:0];
  assign desc.draw_y     = py[11:0];
  assign desc.draw_kind  = dkind_q;
  assign desc.pen        = dpen_q;

  sfsu_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (desc_push),
    .desc_i       (desc),
    .ready_o      (desc_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .pen_o        (pen_o),
    .last_pixel_o (last_pixel_o)
  );

endmodule
`default_nettype wire

// File: bench/starfield_star_update_test.sv
// ----------------------------------------------------------------------------
// starfield_star_update_test
// Drives init and advance beats into the star table, predicts each pixel
// write in the bench and checks it field by field, under random idling.
// ----------------------------------------------------------------------------
module starfield_star_update_test;

  localparam int NSTARS    = 256;
  localparam int IDLE_MAX  = 20000;

  typedef struct packed {
    logic [11:0] px;
    logic [11:0] py;
    logic [1:0]  pen;
    logic        last;
  } pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        func_i = 1'b0;
  logic [7:0]  star_index_i = '0;
  logic [11:0] rand_x_a_i = '0, rand_x_b_i = '0;
  logic [10:0] rand_y_a_i = '0, rand_z_a_i = '0, rand_y_b_i = '0, rand_z_b_i = '0;
  logic [3:0]  rand_speed_a_i = '0, rand_speed_b_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [11:0] pixel_x_o, pixel_y_o;
  logic [1:0]  pen_o;
  logic        last_pixel_o;

  starfield_star_update dut (.*);

  // predictor state
  logic [9:0]  cfg_speed;
  logic [12:0] cfg_width, cfg_height;
  logic [11:0] tx [NSTARS];
  logic [10:0] ty [NSTARS];
  logic [12:0] tz [NSTARS];
  logic [9:0]  tspd [NSTARS];
  logic [11:0] tdx [NSTARS], tdy [NSTARS];
  bit          live [NSTARS];

  pixel_t pending_pixels [$];
  int     n_errors = 0, n_beats = 0, n_pixels = 0, idle_cycles = 0;
  bit     rx_idle_on = 1'b1, tx_idle_on = 1'b1;
  int     rx_holdoff = 0;

  initial forever #4 clk_i = ~clk_i;

  // Stall watchdog: count cycles with no beat on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_MAX) begin
      $display("starfield_star_update verification failed");
      $finish;
    end
  end

  // Receiver ready: random stalls, or a long hold-off when requested.
  always @(negedge clk_i) begin
    if (rx_holdoff > 0) begin
      rx_holdoff  <= rx_holdoff - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni && !(rx_idle_on && $urandom_range(99) < 9);
    end
  end

  // Check each pixel beat against the oldest prediction.
  always @(posedge clk_i) begin
    pixel_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_pixels++;
      if (pending_pixels.size() == 0) begin
        $error("pixel beat with nothing expected x=%0d y=%0d", pixel_x_o, pixel_y_o);
        n_errors++;
      end else begin
        e = pending_pixels.pop_front();
        if (pixel_x_o !== e.px) begin
          $error("pixel_x expected %0d got %0d", e.px, pixel_x_o); n_errors++;
        end
        if (pixel_y_o !== e.py) begin
          $error("pixel_y expected %0d got %0d", e.py, pixel_y_o); n_errors++;
        end
        if (pen_o !== e.pen) begin
          $error("pen expected %0d got %0d", e.pen, pen_o); n_errors++;
        end
        if (last_pixel_o !== e.last) begin
          $error("last_pixel expected %0d got %0d", e.last, last_pixel_o); n_errors++;
        end
      end
    end
  end

  function automatic void push_pixel(int x, int y, logic [1:0] p);
    pixel_t e;
    e.px = x[11:0]; e.py = y[11:0]; e.pen = p; e.last = 1'b0;
    pending_pixels.push_back(e);
  endfunction

  // Emit the pixel pattern of a depth band; returns nothing, pushes beats.
  function automatic void push_pattern(int x, int y, int band, logic [1:0] p);
    if (band == 0) begin
      push_pixel(x, y + 1, p);
      push_pixel(x + 1, y + 1, p);
    end
    if (band >= 0 && band <= 4) push_pixel(x + 1, y, p);
    push_pixel(x, y, p);
  endfunction

  function automatic void spawn_star(int i, logic [11:0] rx, logic [10:0] ry,
                                     logic [10:0] rz, logic [3:0] rs);
    tx[i]   = 12'(1500 - int'(rx));
    ty[i]   = 11'(1000 - int'(ry));
    tz[i]   = 13'(1000 + int'(rz));
    tspd[i] = 10'(int'(cfg_speed) + int'(rs));
  endfunction

  // Predict the pixel beats of one star beat and update the star table.
  function automatic void predict_star_beat(logic f, logic [7:0] idx,
      logic [11:0] xa, logic [10:0] ya, logic [10:0] za, logic [3:0] sa,
      logic [11:0] xb, logic [10:0] yb, logic [10:0] zb, logic [3:0] sb);
    int i, z, d, px, py, band;
    logic [1:0] p;
    pixel_t e;
    i = idx;
    if (!f) begin
      spawn_star(i, xa, ya, za, sa);
      tdx[i] = '0; tdy[i] = '0; live[i] = 1'b1;
      return;
    end
    z = $signed(tz[i]);
    push_pattern(tdx[i], tdy[i], z / 200, sfsu_pkg::PEN_ERASE);
    z = z - int'(tspd[i]);
    tz[i] = 13'(z);
    if (z <= -1000) spawn_star(i, xa, ya, za, sa);
    z = $signed(tz[i]);
    d = z + 1000;
    if (d < 1) d = 1;
    px = int'(cfg_width / 2) + (200 * int'($signed(tx[i]))) / d;
    py = int'(cfg_height / 2) + (200 * int'($signed(ty[i]))) / d;
    if (px < 0 || px > int'(cfg_width) - 2 || py < 0 || py > int'(cfg_height) - 2) begin
      spawn_star(i, xb, yb, zb, sb);
      tdx[i] = '0; tdy[i] = '0;
    end else begin
      tdx[i] = px[11:0]; tdy[i] = py[11:0];
      band = z / 200;
      p = sfsu_pkg::PEN_NEAR;
      if (band == 8 || band == 9) p = sfsu_pkg::PEN_MIDDLE;
      else if (band < 0 || band > 9) p = sfsu_pkg::PEN_FAR;
      push_pattern(px, py, band, p);
    end
    e = pending_pixels[$];
    e.last = 1'b1;
    pending_pixels[$] = e;
  endfunction

  // Send one star beat; hold valid and payload until accepted. Valid stays
  // high on return so the next beat can follow with no gap.
  task automatic send_star(logic f, logic [7:0] idx,
      logic [11:0] xa, logic [10:0] ya, logic [10:0] za, logic [3:0] sa,
      logic [11:0] xb, logic [10:0] yb, logic [10:0] zb, logic [3:0] sb);
    while (tx_idle_on && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    func_i <= f; star_index_i <= idx;
    rand_x_a_i <= xa; rand_y_a_i <= ya; rand_z_a_i <= za; rand_speed_a_i <= sa;
    rand_x_b_i <= xb; rand_y_b_i <= yb; rand_z_b_i <= zb; rand_speed_b_i <= sb;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_star_beat(f, idx, xa, ya, za, sa, xb, yb, zb, sb);
    n_beats++;
    @(negedge clk_i);
  endtask

  task automatic send_random(bit allow_init);
    logic f;
    logic [7:0] idx;
    f = allow_init ? ($urandom_range(99) >= 15) : 1'b1;
    idx = 8'($urandom_range(NSTARS - 1));
    if (!live[idx]) f = 1'b0;
    send_star(f, idx, 12'($urandom_range(2999)), 11'($urandom_range(1999)),
              11'($urandom_range(1999)), 4'($urandom_range(9)),
              12'($urandom_range(2999)), 11'($urandom_range(1999)),
              11'($urandom_range(1999)), 4'($urandom_range(9)));
  endtask

  // Wait for all predicted pixels, then let the block settle.
  task automatic drain_pixels();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(sfsu_pkg::reg_e r, logic [31:0] v);
    logic [31:0] exp_rd;
    drain_pixels();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 4'(r) << 2; pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (r)
      sfsu_pkg::REG_BASE_SPEED: begin
        cfg_speed = v[9:0];
        exp_rd    = {22'd0, v[9:0]};
      end
      sfsu_pkg::REG_SCREEN_WIDTH: begin
        cfg_width = v[12:0];
        exp_rd    = {19'd0, v[12:0]};
      end
      default: begin
        cfg_height = v[12:0];
        exp_rd     = {19'd0, v[12:0]};
      end
    endcase
    if (prdata !== exp_rd) begin
      $error("prdata expected %0d got %0d", exp_rd, prdata); n_errors++;
    end
  endtask

  task automatic test_directed();
    // extremes of random fields, and init of low and high stars
    send_star(1'b0, 8'd0, 12'd0, 11'd0, 11'd0, 4'd0, 12'd2999, 11'd1999, 11'd1999, 4'd9);
    send_star(1'b0, 8'd255, 12'd2999, 11'd1999, 11'd1999, 4'd9,
              12'd0, 11'd0, 11'd0, 4'd0);
    send_star(1'b0, 8'd1, 12'd1500, 11'd1000, 11'd0, 4'd0, 12'd1500, 11'd1000, 11'd0, 4'd0);
    // centered star walks toward the viewer through depths 900 down to -200
    repeat (12) send_star(1'b1, 8'd1, 12'd1500, 11'd1000, 11'd0, 4'd9,
                          12'd1500, 11'd1000, 11'd0, 4'd9);
    // corner stars, near and far, advance and stay on screen
    send_star(1'b1, 8'd0, 12'd0, 11'd0, 11'd0, 4'd0, 12'd1500, 11'd1000, 11'd1999, 4'd0);
    send_star(1'b1, 8'd255, 12'd2999, 11'd1999, 11'd1999, 4'd9,
              12'd1500, 11'd1000, 11'd0, 4'd9);
    send_star(1'b1, 8'd0, 12'd1500, 11'd1000, 11'd1999, 4'd9,
              12'd2999, 11'd1999, 11'd1999, 4'd9);
    send_star(1'b1, 8'd255, 12'd1500, 11'd1000, 11'd0, 4'd0, 12'd0, 11'd0, 11'd0, 4'd0);
  endtask

  task automatic test_random(int count);
    repeat (count) send_random(1'b1);
  endtask

  task automatic test_settings();
    // base speeds 0 and 1000, tiny and huge screens
    write_reg(sfsu_pkg::REG_BASE_SPEED, 32'd0);
    write_reg(sfsu_pkg::REG_SCREEN_WIDTH, 32'd16);
    write_reg(sfsu_pkg::REG_SCREEN_HEIGHT, 32'd16);
    test_random(60);
    write_reg(sfsu_pkg::REG_BASE_SPEED, 32'd1000);
    write_reg(sfsu_pkg::REG_SCREEN_WIDTH, 32'd4096);
    write_reg(sfsu_pkg::REG_SCREEN_HEIGHT, 32'd4096);
    test_random(60);
    write_reg(sfsu_pkg::REG_BASE_SPEED, 32'($urandom_range(1000)));
    write_reg(sfsu_pkg::REG_SCREEN_WIDTH, 32'($urandom_range(16, 4096)));
    write_reg(sfsu_pkg::REG_SCREEN_HEIGHT, 32'($urandom_range(16, 4096)));
    test_random(60);
    write_reg(sfsu_pkg::REG_BASE_SPEED, 32'd300);
    write_reg(sfsu_pkg::REG_SCREEN_WIDTH, 32'd640);
    write_reg(sfsu_pkg::REG_SCREEN_HEIGHT, 32'd480);
  endtask

  task automatic test_backpressure();
    // Hold off the receiver so the block fills and stalls its input.
    rx_holdoff = 300;
    repeat (20) send_random(1'b0);
    drain_pixels();
    // No idling on either side for a stretch.
    rx_idle_on = 1'b0; tx_idle_on = 1'b0;
    test_random(80);
    rx_idle_on = 1'b1; tx_idle_on = 1'b1;
  endtask

  initial begin
    cfg_speed = 10'd100; cfg_width = 13'd640; cfg_height = 13'd480;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(60);
    test_settings();
    test_backpressure();
    test_random(60);
    drain_pixels();
    repeat (40) @(negedge clk_i);
    $display("covered %0d star beats and %0d pixel beats over default, tiny, huge",
             n_beats, n_pixels);
    $display("and random screen and speed settings, with long receiver stalls");
    if (n_errors == 0 && pending_pixels.size() == 0) begin
      $display("starfield_star_update verification clean");
    end else begin
      $display("starfield_star_update verification failed");
    end
    $finish;
  end
endmodule
